[hdl/tlc_pkg.sv]
// Package for the two-way traffic light controller: widths, reset values,
// codes, enum and struct types and small helper functions.
// Depends on nothing; the arithmetic unit and the core use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

  localparam int CNT_W       = 19;
  localparam int PROD_W      = 17;
  localparam int DUR_W       = 7;
  localparam int TPS_W       = 10;
  localparam int HALF_W      = TPS_W - 1;
  localparam int LOCK_W      = 10;
  localparam int REM_W       = TPS_W;
  localparam int DIVC_W      = 5;
  localparam int LAMP_W      = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DUR_W-1:0]  MAX_SECONDS = 7'd99;
  localparam logic [TPS_W-1:0]  RESET_TPS   = 10'd100;
  localparam logic [LOCK_W-1:0] LOCK_MAX    = 10'd1023;
  localparam logic [DIVC_W-1:0] DIV_LAST    = DIVC_W'(CNT_W - 1);

  localparam logic [0:0] REG_TPS = 1'b0;

  localparam logic [1:0] C_RED = 2'd0;
  localparam logic [1:0] C_YEL = 2'd1;
  localparam logic [1:0] C_GRN = 2'd2;

  localparam logic [DUR_W-1:0] DUR_RED_RST = 7'd5;
  localparam logic [DUR_W-1:0] DUR_YEL_RST = 7'd2;
  localparam logic [DUR_W-1:0] DUR_GRN_RST = 7'd3;

  localparam logic [LAMP_W-1:0] LAMP_OFF = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_RED = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_YEL = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_GRN = 3'b100;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_EDIT_RED = 2'd1,
    MODE_EDIT_YEL = 2'd2,
    MODE_EDIT_GRN = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_Y,
    ST_MUL_G,
    ST_ADD_RY,
    ST_ADD_YG,
    ST_ADD_T,
    ST_DIV,
    ST_UPDATE
  } seq_state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_DSTEP
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  function automatic logic [DUR_W-1:0] reset_dur(input logic [1:0] c);
    logic [DUR_W-1:0] d;
    unique case (c)
      C_RED:   d = DUR_RED_RST;
      C_YEL:   d = DUR_YEL_RST;
      default: d = DUR_GRN_RST;
    endcase
    return d;
  endfunction

  function automatic logic [LAMP_W-1:0] color_lamp(input logic [1:0] c);
    logic [LAMP_W-1:0] l;
    unique case (c)
      C_RED:   l = LAMP_RED;
      C_YEL:   l = LAMP_YEL;
      C_GRN:   l = LAMP_GRN;
      default: l = LAMP_OFF;
    endcase
    return l;
  endfunction

  // Road A runs red, green, yellow; road B runs green, yellow, red.
  function automatic logic [1:0] road_color(input logic road, input logic [1:0] p);
    logic [1:0] c;
    if (!road) begin
      unique case (p)
        2'd0:    c = C_RED;
        2'd1:    c = C_GRN;
        default: c = C_YEL;
      endcase
    end else begin
      unique case (p)
        2'd0:    c = C_GRN;
        2'd1:    c = C_YEL;
        default: c = C_RED;
      endcase
    end
    return c;
  endfunction

  function automatic logic [1:0] phase_mod3(input logic [1:0] p);
    return (p == 2'd3) ? 2'd0 : p;
  endfunction

  function automatic logic [LOCK_W-1:0] lock_inc(input logic [LOCK_W-1:0] v);
    return (v == LOCK_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

[hdl/tlc_ifs.sv]
// Handshake channel interfaces for tick items and result items.
// Depends on nothing but the payload widths of the controller.
`timescale 1ns / 1ps
`default_nettype none

interface tlc_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic mode_button;
  logic increment_button;
  logic commit_button;

  modport source(output valid, tick, mode_button, increment_button, commit_button,
                 input ready);
  modport sink(input valid, tick, mode_button, increment_button, commit_button,
               output ready);
endinterface

interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] lamps_road_a;
  logic [2:0] lamps_road_b;
  logic [6:0] display_a_value;
  logic [6:0] display_b_value;
  logic       digit_select;
  logic       refresh;
  logic [1:0] current_mode;

  modport source(output valid, lamps_road_a, lamps_road_b, display_a_value,
                 display_b_value, digit_select, refresh, current_mode, input ready);
  modport sink(input valid, lamps_road_a, lamps_road_b, display_a_value,
               display_b_value, digit_select, refresh, current_mode, output ready);
endinterface

`default_nettype wire

[hdl/tlc_arith.sv]
// Shared arithmetic unit: small multiply, wide add, or one restoring
// division step. Depends on tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlc_arith (
  input  tlc_pkg::alu_req_t               req,
  output logic [tlc_pkg::CNT_W-1:0]       y
);

  always_comb begin
    unique case (req.op)
      tlc_pkg::OP_MUL:
        y = tlc_pkg::CNT_W'(tlc_pkg::PROD_W'(req.a[tlc_pkg::DUR_W-1:0]) *
                            tlc_pkg::PROD_W'(req.b[tlc_pkg::TPS_W-1:0]));
      tlc_pkg::OP_ADD:
        y = req.a + req.b;
      tlc_pkg::OP_DSTEP:
        y = (req.a >= req.b) ? req.a - req.b : req.a;
      default:
        y = req.a;
    endcase
  end

endmodule

`default_nettype wire

[hdl/two_way_traffic_light_controller_core.sv]
// A tick item passes through the states of the shared arithmetic unit: three
// multiplies and three adds, then 19 restoring division steps that test the
// cycle count against the tick rate, then the update; an item with tick 0
// goes straight to the update. The input is not ready again until the item
// has left the update state, which waits while the output is stalled.
// Synchronous active-low reset loads the power-up state directly; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module two_way_traffic_light_controller_core (
  input  logic                               clk,
  input  logic                               rst_n,
  tlc_in_if.sink                             in_item,
  tlc_out_if.source                          out_item,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tlc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tlc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = tlc_pkg::CNT_W;
  localparam int DW = tlc_pkg::DUR_W;
  localparam int LW = tlc_pkg::LOCK_W;
  localparam int TW = tlc_pkg::TPS_W;
  localparam int PW = tlc_pkg::PROD_W;
  localparam int AW = tlc_pkg::LAMP_W;

  tlc_pkg::seq_state_t state_r, state_nxt;

  logic [TW-1:0]              tps_r;
  logic                       tick_r, mb_r, ib_r, cb_r;
  logic [PW-1:0]              r_r, y_r, g_r;
  logic [CW-1:0]              ry_r, yg_r, t_r;
  logic [tlc_pkg::REM_W-1:0]  rem_r;
  logic [CW-1:0]              dvd_r;
  logic [tlc_pkg::DIVC_W-1:0] divc_r;

  tlc_pkg::mode_t  mode_r, mode_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      phase_r [2];
  logic [1:0]      phase_nxt [2];
  logic [DW-1:0]   cd_r [2][3];
  logic [DW-1:0]   cd_nxt [2][3];
  logic [DW-1:0]   com_r [3];
  logic [DW-1:0]   com_nxt [3];
  logic [DW-1:0]   pend_r [3];
  logic [DW-1:0]   pend_nxt [3];
  logic [LW-1:0]   lock_r [3];
  logic [LW-1:0]   lock_nxt [3];
  logic [TW-1:0]   blink_r, blink_nxt;
  logic [TW-1:0]   refr_r, refr_nxt;
  logic            tog_r, tog_nxt;
  logic [DW-1:0]   disp_r [2];
  logic [DW-1:0]   disp_nxt [2];
  logic [AW-1:0]   lamp_r [2];
  logic [AW-1:0]   lamp_nxt [2];
  logic            dsel_nxt, refresh_nxt;

  logic                 out_valid_r;
  logic [AW-1:0]        o_lamp_a_r, o_lamp_b_r;
  logic [DW-1:0]        o_disp_a_r, o_disp_b_r;
  logic                 o_dsel_r, o_refresh_r;
  logic [1:0]           o_mode_r;

  logic [TW-1:0]             eff_tps;
  logic [tlc_pkg::HALF_W-1:0] half;
  logic                      in_accept, out_free, commit, leave;
  tlc_pkg::alu_req_t         alu_req;
  logic [CW-1:0]             alu_y;

  assign eff_tps   = (tps_r == '0) ? TW'(1) : tps_r;
  assign half      = eff_tps[TW-1:1];
  assign in_accept = in_item.valid && in_item.ready;
  assign out_free  = !out_valid_r || out_item.ready;
  assign commit    = (state_r == tlc_pkg::ST_UPDATE) && out_free;
  assign leave     = mb_r && (lock_r[0] >= LW'(half)) && (mode_r == tlc_pkg::MODE_EDIT_GRN);

  // Configuration port.
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == tlc_pkg::REG_TPS) begin
      cfg_prdata = tlc_pkg::CFG_DATA_W'(tps_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= tlc_pkg::RESET_TPS;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == tlc_pkg::REG_TPS) begin
      tps_r <= cfg_pwdata[TW-1:0];
    end
  end

  tlc_arith u_arith (
    .req (alu_req),
    .y   (alu_y)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlc_pkg::ST_IDLE: begin
        if (in_item.valid) begin
          state_nxt = in_item.tick ? tlc_pkg::ST_MUL_R : tlc_pkg::ST_UPDATE;
        end
      end
      tlc_pkg::ST_MUL_R:  state_nxt = tlc_pkg::ST_MUL_Y;
      tlc_pkg::ST_MUL_Y:  state_nxt = tlc_pkg::ST_MUL_G;
      tlc_pkg::ST_MUL_G:  state_nxt = tlc_pkg::ST_ADD_RY;
      tlc_pkg::ST_ADD_RY: state_nxt = tlc_pkg::ST_ADD_YG;
      tlc_pkg::ST_ADD_YG: state_nxt = tlc_pkg::ST_ADD_T;
      tlc_pkg::ST_ADD_T:  state_nxt = tlc_pkg::ST_DIV;
      tlc_pkg::ST_DIV: begin
        if (divc_r == tlc_pkg::DIV_LAST) begin
          state_nxt = tlc_pkg::ST_UPDATE;
        end
      end
      tlc_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = tlc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operands of the shared unit.
  always_comb begin
    in_item.ready = (state_r == tlc_pkg::ST_IDLE);
    alu_req.op    = tlc_pkg::OP_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_r)
      tlc_pkg::ST_MUL_R: begin
        alu_req.op = tlc_pkg::OP_MUL;
        alu_req.a  = CW'(com_r[tlc_pkg::C_RED]);
        alu_req.b  = CW'(eff_tps);
      end
      tlc_pkg::ST_MUL_Y: begin
        alu_req.op = tlc_pkg::OP_MUL;
        alu_req.a  = CW'(com_r[tlc_pkg::C_YEL]);
        alu_req.b  = CW'(eff_tps);
      end
      tlc_pkg::ST_MUL_G: begin
        alu_req.op = tlc_pkg::OP_MUL;
        alu_req.a  = CW'(com_r[tlc_pkg::C_GRN]);
        alu_req.b  = CW'(eff_tps);
      end
      tlc_pkg::ST_ADD_RY: begin
        alu_req.a = CW'(r_r);
        alu_req.b = CW'(y_r);
      end
      tlc_pkg::ST_ADD_YG: begin
        alu_req.a = CW'(y_r);
        alu_req.b = CW'(g_r);
      end
      tlc_pkg::ST_ADD_T: begin
        alu_req.a = ry_r;
        alu_req.b = CW'(g_r);
      end
      tlc_pkg::ST_DIV: begin
        alu_req.op = tlc_pkg::OP_DSTEP;
        alu_req.a  = CW'({rem_r, dvd_r[CW-1]});
        alu_req.b  = CW'(eff_tps);
      end
      default: begin
        alu_req.op = tlc_pkg::OP_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r <= in_item.tick;
      mb_r   <= in_item.mode_button;
      ib_r   <= in_item.increment_button;
      cb_r   <= in_item.commit_button;
    end
    unique case (state_r)
      tlc_pkg::ST_MUL_R:  r_r  <= alu_y[PW-1:0];
      tlc_pkg::ST_MUL_Y:  y_r  <= alu_y[PW-1:0];
      tlc_pkg::ST_MUL_G:  g_r  <= alu_y[PW-1:0];
      tlc_pkg::ST_ADD_RY: ry_r <= alu_y;
      tlc_pkg::ST_ADD_YG: yg_r <= alu_y;
      tlc_pkg::ST_ADD_T: begin
        t_r    <= alu_y;
        dvd_r  <= leave ? alu_y : cnt_r;
        rem_r  <= '0;
        divc_r <= '0;
      end
      tlc_pkg::ST_DIV: begin
        rem_r  <= alu_y[tlc_pkg::REM_W-1:0];
        dvd_r  <= {dvd_r[CW-2:0], 1'b0};
        divc_r <= divc_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Effect of one item on the controller state.
  always_comb begin : update_logic
    logic            press;
    logic [1:0]      c;
    logic [1:0]      p;
    logic [1:0]      col;
    logic [CW-1:0]   t;
    logic            le_t, gt_yg, gt_y, gt_ry, gt_r, gt_0;

    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    phase_nxt   = phase_r;
    cd_nxt      = cd_r;
    com_nxt     = com_r;
    pend_nxt    = pend_r;
    lock_nxt    = lock_r;
    blink_nxt   = blink_r;
    refr_nxt    = refr_r;
    tog_nxt     = tog_r;
    disp_nxt    = disp_r;
    lamp_nxt    = lamp_r;
    dsel_nxt    = 1'b0;
    refresh_nxt = 1'b0;
    press       = mb_r && (lock_r[0] >= LW'(half));
    c           = 2'd0;
    p           = 2'd0;
    col         = 2'd0;
    t           = '0;
    le_t        = 1'b0;
    gt_yg       = 1'b0;
    gt_y        = 1'b0;
    gt_ry       = 1'b0;
    gt_r        = 1'b0;
    gt_0        = 1'b0;

    if (tick_r) begin
      if (press) begin
        if (mode_r != tlc_pkg::MODE_EDIT_GRN) begin
          lamp_nxt[0] = tlc_pkg::LAMP_OFF;
          lamp_nxt[1] = tlc_pkg::LAMP_OFF;
          tog_nxt     = 1'b0;
          mode_nxt    = tlc_pkg::mode_t'(mode_r + 2'd1);
          disp_nxt[0] = com_r[mode_r];
          disp_nxt[1] = DW'(mode_nxt);
        end else begin
          cnt_nxt = t_r;
          for (int r = 0; r < 2; r++) begin
            phase_nxt[r] = 2'd0;
            for (int k = 0; k < 3; k++) begin
              cd_nxt[r][k] = com_r[k];
            end
          end
          disp_nxt[0] = '0;
          disp_nxt[1] = '0;
          refr_nxt    = TW'(half);
          pend_nxt    = com_r;
          mode_nxt    = tlc_pkg::MODE_NORMAL;
        end
        lock_nxt[0] = '0;
      end
      lock_nxt[0] = tlc_pkg::lock_inc(lock_nxt[0]);

      if (mode_nxt == tlc_pkg::MODE_NORMAL) begin
        t     = cnt_nxt;
        le_t  = (t <= t_r);
        gt_yg = (t > yg_r);
        gt_y  = (t > CW'(y_r));
        gt_ry = (t > ry_r);
        gt_r  = (t > CW'(r_r));
        gt_0  = (t != '0);
        priority if (le_t && gt_yg)  lamp_nxt[0] = tlc_pkg::LAMP_RED;
        else if (!gt_yg && gt_y)     lamp_nxt[0] = tlc_pkg::LAMP_GRN;
        else if (!gt_y && gt_0)      lamp_nxt[0] = tlc_pkg::LAMP_YEL;
        if (rem_r == '0) begin
          for (int r = 0; r < 2; r++) begin
            p           = tlc_pkg::phase_mod3(phase_nxt[r]);
            col         = tlc_pkg::road_color(1'(r), p);
            disp_nxt[r] = cd_nxt[r][col];
            if (cd_nxt[r][col] <= DW'(1)) begin
              phase_nxt[r]   = (p == 2'd2) ? 2'd0 : p + 2'd1;
              cd_nxt[r][col] = com_nxt[col];
            end else begin
              cd_nxt[r][col] = cd_nxt[r][col] - 1'b1;
            end
          end
        end
        priority if (le_t && gt_ry)  lamp_nxt[1] = tlc_pkg::LAMP_GRN;
        else if (!gt_ry && gt_r)     lamp_nxt[1] = tlc_pkg::LAMP_YEL;
        else if (!gt_r && gt_0)      lamp_nxt[1] = tlc_pkg::LAMP_RED;
      end else begin
        c = 2'(mode_nxt) - 2'd1;
        if (blink_r <= TW'(1)) begin
          lamp_nxt[0] = lamp_nxt[0] ^ tlc_pkg::color_lamp(c);
          lamp_nxt[1] = lamp_nxt[1] ^ tlc_pkg::color_lamp(c);
          blink_nxt   = TW'(half);
        end else begin
          blink_nxt = blink_r - 1'b1;
        end
        if (ib_r && lock_r[1] >= LW'(half)) begin
          if (pend_nxt[c] < tlc_pkg::MAX_SECONDS) begin
            pend_nxt[c] = pend_nxt[c] + 1'b1;
          end
          disp_nxt[0] = pend_nxt[c];
          lock_nxt[1] = '0;
        end
        if (cb_r && lock_r[2] >= LW'(half)) begin
          com_nxt[c]  = pend_nxt[c];
          disp_nxt[0] = com_nxt[c];
          lock_nxt[2] = '0;
        end
      end

      if (refr_nxt == '0) begin
        dsel_nxt    = tog_nxt;
        tog_nxt     = !tog_nxt;
        refresh_nxt = 1'b1;
        refr_nxt    = TW'(half);
      end

      if (mode_nxt == tlc_pkg::MODE_NORMAL) begin
        if (cnt_nxt == '0) begin
          cnt_nxt = t_r;
        end
        if (cnt_nxt != '0) begin
          cnt_nxt = cnt_nxt - 1'b1;
        end
      end else begin
        lock_nxt[1] = tlc_pkg::lock_inc(lock_nxt[1]);
        lock_nxt[2] = tlc_pkg::lock_inc(lock_nxt[2]);
      end
      if (refr_nxt != '0) begin
        refr_nxt = refr_nxt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tlc_pkg::MODE_NORMAL;
      cnt_r   <= CW'(10 * tlc_pkg::RESET_TPS);
      blink_r <= TW'(tlc_pkg::RESET_TPS >> 1);
      refr_r  <= TW'(tlc_pkg::RESET_TPS >> 1);
      tog_r   <= 1'b0;
      for (int r = 0; r < 2; r++) begin
        phase_r[r] <= 2'd0;
        disp_r[r]  <= '0;
        lamp_r[r]  <= tlc_pkg::LAMP_OFF;
        for (int k = 0; k < 3; k++) begin
          cd_r[r][k] <= tlc_pkg::reset_dur(2'(k));
        end
      end
      for (int k = 0; k < 3; k++) begin
        com_r[k]  <= tlc_pkg::reset_dur(2'(k));
        pend_r[k] <= tlc_pkg::reset_dur(2'(k));
        lock_r[k] <= LW'(tlc_pkg::RESET_TPS >> 1);
      end
    end else if (commit) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      com_r   <= com_nxt;
      pend_r  <= pend_nxt;
      lock_r  <= lock_nxt;
      blink_r <= blink_nxt;
      refr_r  <= refr_nxt;
      tog_r   <= tog_nxt;
      disp_r  <= disp_nxt;
      lamp_r  <= lamp_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      o_lamp_a_r  <= lamp_nxt[0];
      o_lamp_b_r  <= lamp_nxt[1];
      o_disp_a_r  <= disp_nxt[0];
      o_disp_b_r  <= disp_nxt[1];
      o_dsel_r    <= dsel_nxt;
      o_refresh_r <= refresh_nxt;
      o_mode_r    <= 2'(mode_nxt);
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.lamps_road_a    = o_lamp_a_r;
  assign out_item.lamps_road_b    = o_lamp_b_r;
  assign out_item.display_a_value = o_disp_a_r;
  assign out_item.display_b_value = o_disp_b_r;
  assign out_item.digit_select    = o_dsel_r;
  assign out_item.refresh         = o_refresh_r;
  assign out_item.current_mode    = o_mode_r;

endmodule

`default_nettype wire

[hdl/tlc_chk.sv]
// Port-level checker for the traffic light controller core, with the bind
// statement that attaches it. Depends on the core's ports only.
`timescale 1ns / 1ps
`default_nettype none

module tlc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] lamps_a,
  input logic [2:0] lamps_b,
  input logic [6:0] disp_a,
  input logic       dsel,
  input logic       refresh
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in progress");

  a_dsel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !refresh |-> dsel == 1'b0)
    else $error("digit select set without a refresh");

  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(lamps_a) && $onehot0(lamps_b))
    else $error("more than one lamp lit on a road");

  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> disp_a <= 7'd99)
    else $error("display value above the duration limit");

endmodule

bind two_way_traffic_light_controller_core tlc_chk u_tlc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .lamps_a   (out_item.lamps_road_a),
  .lamps_b   (out_item.lamps_road_b),
  .disp_a    (out_item.display_a_value),
  .dsel      (out_item.digit_select),
  .refresh   (out_item.refresh)
);

`default_nettype wire
